@@ rtl/rwca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwca_pkg: shared types and constants for the receive window
// Sequence width, window size and the status codes returned with each ack.
// ----------------------------------------------------------------------------
package rwca_pkg;

  localparam int SEQ_W    = 31;
  // Window of tracked numbers; a power of two so the slot is the low bits.
  localparam int WINDOW   = 64;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int STATUS_W = 3;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [WINDOW-1:0] miss_map_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IN_ORDER = 3'd0,
    ST_GAP      = 3'd1,
    ST_HOLE     = 3'd2,
    ST_DUP      = 3'd3,
    ST_REJECT   = 3'd4
  } status_t;

endpackage : rwca_pkg
`default_nettype wire

@@ rtl/rwca_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwca_if: valid/ready channels of the receive window
// Input channel carries a sequence number, output channel the ack and status.
// ----------------------------------------------------------------------------
interface rwca_in_if import rwca_pkg::*; ();
  logic valid;
  logic ready;
  seq_t seq;

  modport source (output valid, output seq, input ready);
  modport sink   (input valid, input seq, output ready);
endinterface : rwca_in_if

interface rwca_out_if import rwca_pkg::*; ();
  logic                valid;
  logic                ready;
  seq_t                cumulative_ack;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output cumulative_ack, output status, input ready);
  modport sink   (input valid, input cumulative_ack, input status, output ready);
endinterface : rwca_out_if
`default_nettype wire

@@ rtl/receive_window_cumulative_ack.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// receive_window_cumulative_ack: receive window with cumulative ack
// Usage:
//   in_chan  carries one received sequence number per word.
//   out_chan returns one word per input word: the cumulative ack (every number
//            up to it has arrived) and a status code (in order, gap opened,
//            hole filled, duplicate/stale, out of window rejected).
//   The result is registered: a word accepted at a clock edge shows on out_chan
//   right after that edge. Throughput is one word per cycle while the receiver
//   takes results; the window update and the search for the oldest missing
//   number are done in the same cycle over a WINDOW-bit map held in flip-flops.
//   The input stays ready while the output register is empty or being taken
//   in the same cycle; when the receiver stalls, the result holds and the
//   input drops ready until it is taken.
//   Reset (synchronous, active low) clears the highest number, the ack and
//   the missing map, and empties the output register. No clearing pass.
// ----------------------------------------------------------------------------
module receive_window_cumulative_ack import rwca_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  rwca_in_if.sink    in_chan,
  rwca_out_if.source out_chan
);

  seq_t      highest_r, highest_nxt;
  seq_t      ack_r;
  miss_map_t miss_r, miss_nxt;
  logic      out_valid_r;
  seq_t      out_ack_r;
  status_t   out_status_r;

  logic      accept;
  seq_t      seq;
  slot_t     seq_slot;
  logic      above;
  logic      too_far;
  logic      in_range;
  seq_t      gap;
  miss_map_t gap_mask;
  status_t   status;
  slot_t     h_slot;
  miss_map_t rot;
  slot_t     oldest_k;
  logic      found;
  seq_t      ack_calc;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign seq           = in_chan.seq;
  assign seq_slot      = seq[SLOT_W-1:0];

  assign above    = seq > highest_r;
  assign too_far  = ({1'b0, seq} - {1'b0, ack_r}) > (SEQ_W+1)'(WINDOW);
  assign gap      = seq - highest_r - SEQ_W'(1);
  assign in_range = (seq != '0) && (seq < highest_r) &&
                    (({1'b0, seq} + (SEQ_W+1)'(WINDOW)) > {1'b0, highest_r});

  // Mark slots whose number lies strictly between the old highest and seq
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      slot_t d;
      d = seq_slot - SLOT_W'(i);
      gap_mask[i] = (d != '0) && (SEQ_W'(d) <= gap);
    end
  end

  always_comb begin
    miss_nxt    = miss_r;
    highest_nxt = highest_r;
    if (above) begin
      if (too_far) begin
        status = ST_REJECT;
      end else begin
        status      = (gap == '0) ? ST_IN_ORDER : ST_GAP;
        miss_nxt    = miss_r | gap_mask;
        highest_nxt = seq;
      end
    end else if (in_range && miss_r[seq_slot]) begin
      status             = ST_HOLE;
      miss_nxt[seq_slot] = 1'b0;
    end else begin
      status = ST_DUP;
    end
  end

  // Oldest missing number: largest distance back from the new highest
  assign h_slot = highest_nxt[SLOT_W-1:0];

  always_comb begin
    rot[0] = 1'b0;
    for (int k = 1; k < WINDOW; k++) begin
      rot[k] = miss_nxt[h_slot - SLOT_W'(k)];
    end
  end

  always_comb begin
    oldest_k = '0;
    for (int k = 1; k < WINDOW; k++) begin
      if (rot[k]) begin
        oldest_k = SLOT_W'(k);
      end
    end
  end

  assign found    = |rot;
  assign ack_calc = found ? (highest_nxt - SEQ_W'(oldest_k) - SEQ_W'(1)) : highest_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_r   <= '0;
      ack_r       <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        highest_r   <= highest_nxt;
        ack_r       <= ack_calc;
        miss_r      <= miss_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ack_r    <= ack_calc;
      out_status_r <= status;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.cumulative_ack = out_ack_r;
  assign out_chan.status         = out_status_r;

endmodule : receive_window_cumulative_ack
`default_nettype wire

@@ test/receive_window_cumulative_ack_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_window_cumulative_ack_tb: self-checking bench for the receive window
// Feeds sequence numbers in bursts against a stalling receiver. A local copy
// of the window predicts each ack word, and the monitor compares every
// returned word against the oldest prediction.
// ----------------------------------------------------------------------------
module receive_window_cumulative_ack_tb;
  import rwca_pkg::*;

  localparam int RANDOM_ITEMS = 1131;
  localparam int IDLE_LIMIT   = 1000;
  localparam int LONG_HOLD    = 200;

  typedef struct packed {
    seq_t      top;
    miss_map_t miss;
  } window_t;

  typedef struct packed {
    seq_t    ack;
    status_t status;
  } ack_word_t;

  logic clk = 1'b0;
  logic rst_n;

  rwca_in_if  in_ch ();
  rwca_out_if out_ch ();

  receive_window_cumulative_ack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always #4 clk = ~clk;

  seq_t      pending_seqs[$];
  ack_word_t expected_acks[$];
  window_t   gen_win;
  window_t   chk_win;
  int        mismatches = 0;
  int        hold_requests = 0;
  int        holds_served = 0;

  // Oldest missing number minus one, or the top if nothing is missing.
  function automatic seq_t window_ack(input window_t w);
    logic [31:0] n;
    logic [31:0] first;
    first = (32'(w.top) >= 32'(WINDOW)) ? 32'(w.top) - 32'(WINDOW) + 32'd1 : 32'd1;
    for (n = first; n < 32'(w.top); n++) begin
      if (w.miss[n[SLOT_W-1:0]]) return seq_t'(n - 32'd1);
    end
    return w.top;
  endfunction

  function automatic ack_word_t window_step(inout window_t w, input seq_t s);
    ack_word_t   r;
    logic [31:0] n;
    seq_t        a;
    a = window_ack(w);
    if (s > w.top) begin
      if (32'(s) - 32'(a) > 32'(WINDOW)) begin
        r.status = ST_REJECT;
      end else begin
        r.status = (32'(s) == 32'(w.top) + 32'd1) ? ST_IN_ORDER : ST_GAP;
        for (n = 32'(w.top) + 32'd1; n < 32'(s); n++) w.miss[n[SLOT_W-1:0]] = 1'b1;
        w.top = s;
        a = window_ack(w);
      end
    end else if (s >= 1 && s < w.top && 32'(s) + 32'(WINDOW) > 32'(w.top) &&
                 w.miss[s[SLOT_W-1:0]]) begin
      w.miss[s[SLOT_W-1:0]] = 1'b0;
      r.status = ST_HOLE;
      a = window_ack(w);
    end else begin
      r.status = ST_DUP;
    end
    r.ack = a;
    return r;
  endfunction

  // Mostly well-formed traffic around the window, some stale and wild numbers.
  function automatic seq_t next_random_seq(input window_t w);
    logic [31:0] a;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] first;
    logic [31:0] span;
    logic [31:0] n;
    int          off;
    int          pick;
    a    = 32'(window_ack(w));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      return seq_t'(32'(w.top) + 32'd1);
    end else if (pick < 50) begin
      lo = 32'(w.top) + 32'd2;
      hi = a + 32'(WINDOW);
      if (hi >= lo) return seq_t'($urandom_range(hi, lo));
      return seq_t'(32'(w.top) + 32'd1);
    end else if (pick < 75) begin
      first = (32'(w.top) >= 32'(WINDOW)) ? 32'(w.top) - 32'(WINDOW) + 32'd1 : 32'd1;
      span  = (32'(w.top) > first) ? 32'(w.top) - first : 32'd0;
      off   = $urandom_range(0, WINDOW - 1);
      for (int k = 0; k < WINDOW && span != 0; k++) begin
        n = first + (32'(off + k) % span);
        if (w.miss[n[SLOT_W-1:0]]) return seq_t'(n);
      end
      return seq_t'($urandom_range(32'(w.top), 0));
    end else if (pick < 85) begin
      return seq_t'($urandom_range(32'(w.top), 0));
    end else if (pick < 93) begin
      return seq_t'(a + 32'(WINDOW) + 32'd1 + 32'($urandom_range(0, 300)));
    end
    return seq_t'($urandom());
  endfunction

  task automatic queue_seq(input seq_t s);
    pending_seqs.push_back(s);
    void'(window_step(gen_win, s));
  endtask

  // Wait while a word is queued, on the input bus, or still owed on the output.
  task automatic drain_all();
    while (pending_seqs.size() != 0 || in_ch.valid || expected_acks.size() != 0)
      @(posedge clk);
  endtask

  // Driver: bursts of words with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    logic nxt_valid;
    seq_t nxt_seq;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.seq   <= '0;
    end else begin
      nxt_valid = in_ch.valid;
      nxt_seq   = in_ch.seq;
      if (in_ch.valid && in_ch.ready) begin
        void'(pending_seqs.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_seqs.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_seq   = pending_seqs[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_ch.valid <= nxt_valid;
      in_ch.seq   <= nxt_seq;
    end
  end

  // Monitor: predicts on input words, checks output words, drives ready.
  int ready_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    ack_word_t want;
    logic      in_acc;
    logic      out_acc;
    logic      nxt_ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      in_acc  = in_ch.valid && in_ch.ready;
      out_acc = out_ch.valid && out_ch.ready;
      if (in_acc) expected_acks.push_back(window_step(chk_win, in_ch.seq));
      if (out_acc) begin
        if (expected_acks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: ack %0d status %0d",
                     out_ch.cumulative_ack, out_ch.status);
        end else begin
          want = expected_acks.pop_front();
          if (want.ack !== out_ch.cumulative_ack || want.status !== out_ch.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ack %0d status %0d, got ack %0d status %0d",
                       want.ack, want.status, out_ch.cumulative_ack, out_ch.status);
          end
        end
      end

      if (in_acc || out_acc) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end

      // Hold off the receiver for a long stretch when asked, else follow the pattern.
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (ready_mode == 0) begin
        nxt_ready = 1'b1;
      end else if (ready_mode == 1) begin
        nxt_ready = $urandom_range(0, 1);
      end else begin
        nxt_ready = ($urandom_range(0, 3) == 0);
      end
      out_ch.ready <= nxt_ready;
    end
  end

  initial begin
    seq_t directed_seqs[$];
    directed_seqs = '{
      31'd0, 31'd1, 31'd2, 31'd5, 31'd3, 31'd3, 31'd4, 31'd1,
      31'd70, 31'd69, 31'd68, 31'd6, 31'h7FFF_FFFF, 31'h2AAA_AAAA, 31'h5555_5555,
      31'd132, 31'd70, 31'd40, 31'd39, 31'd0, 31'd72
    };
    in_ch.valid  = 1'b0;
    in_ch.seq    = '0;
    out_ch.ready = 1'b0;
    gen_win      = '0;
    chk_win      = '0;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_seqs[i]) queue_seq(directed_seqs[i]);
    drain_all();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      while (pending_seqs.size() >= 24) @(posedge clk);
      if (k == 300) hold_requests++;
      // stop feeding until every ack word is back
      if (k == 700) drain_all();
      queue_seq(next_random_seq(gen_win));
    end

    drain_all();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_acks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : receive_window_cumulative_ack_tb

@@ receive_window_cumulative_ack.f @@
rtl/rwca_pkg.sv
rtl/rwca_if.sv
rtl/receive_window_cumulative_ack.sv
test/receive_window_cumulative_ack_tb.sv
